// ===== rtl/irbde_pkg.sv =====
// ----------------------------------------------------------------------------
// irbde_pkg
// shared types, constants and tables for the ir ball direction estimator
// ----------------------------------------------------------------------------
`default_nettype none

package irbde_pkg;

   localparam int NumSensors         = 16;
   localparam int WindowHalfDefault  = 2;
   localparam int CordicStepsDefault = 16;

   localparam int LevelWidth = 7;
   localparam int AccWidth   = 16;
   localparam int AngWidth   = 28;
   localparam int CordWidth  = 44;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_raw;
      logic smooth_start;
      logic smooth_step;
      logic fill_step;
      logic sum_start;
      logic sum_step;
      logic cordic_start;
      logic cordic_step;
      logic finish;
   } cmd_type;

   // status from the datapath
   typedef struct packed {
      logic ball_seen;
      logic cordic_done;
   } status_type;

   function automatic logic signed [16:0] sin_q15(input logic [3:0] t);
      logic signed [16:0] v;
      unique case (t)
         4'd0:  v = 17'sd0;
         4'd1:  v = 17'sd12540;
         4'd2:  v = 17'sd23171;
         4'd3:  v = 17'sd30274;
         4'd4:  v = 17'sd32768;
         4'd5:  v = 17'sd30274;
         4'd6:  v = 17'sd23171;
         4'd7:  v = 17'sd12540;
         4'd8:  v = 17'sd0;
         4'd9:  v = -17'sd12540;
         4'd10: v = -17'sd23171;
         4'd11: v = -17'sd30274;
         4'd12: v = -17'sd32768;
         4'd13: v = -17'sd30274;
         4'd14: v = -17'sd23171;
         default: v = -17'sd12540;
      endcase
      return v;
   endfunction

   function automatic logic signed [16:0] cos_q15(input logic [3:0] t);
      return sin_q15(t + 4'd4);
   endfunction

   function automatic logic [22:0] atan_q16(input logic [4:0] i);
      logic [22:0] v;
      unique case (i)
         5'd0:  v = 23'd2949120;
         5'd1:  v = 23'd1740967;
         5'd2:  v = 23'd919879;
         5'd3:  v = 23'd466945;
         5'd4:  v = 23'd234379;
         5'd5:  v = 23'd117304;
         5'd6:  v = 23'd58666;
         5'd7:  v = 23'd29335;
         5'd8:  v = 23'd14668;
         5'd9:  v = 23'd7334;
         5'd10: v = 23'd3667;
         5'd11: v = 23'd1833;
         5'd12: v = 23'd917;
         5'd13: v = 23'd458;
         5'd14: v = 23'd229;
         5'd15: v = 23'd115;
         5'd16: v = 23'd57;
         5'd17: v = 23'd29;
         5'd18: v = 23'd14;
         5'd19: v = 23'd7;
         5'd20: v = 23'd4;
         5'd21: v = 23'd2;
         5'd22: v = 23'd1;
         default: v = 23'd0;
      endcase
      return v;
   endfunction

   // raw / 1000 for a 16 bit sample, via reciprocal multiply (exact over 16 bits)
   function automatic logic [6:0] div1000(input logic [15:0] raw);
      logic [34:0] prod;
      prod = 35'(raw) * 35'd268436;
      return prod[34:28];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/irbde_ctrl.sv =====
// ----------------------------------------------------------------------------
// irbde_ctrl
// sequencer: smoothing walk, fill, window sum, cordic and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module irbde_ctrl #(
   parameter int WINDOW_HALF  = irbde_pkg::WindowHalfDefault,
   parameter int CORDIC_STEPS = irbde_pkg::CordicStepsDefault
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire  [2:0]            req_pos,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output irbde_pkg::cmd_type    cmd,
   input  irbde_pkg::status_type status
);

   localparam int NumSensors = irbde_pkg::NumSensors;
   localparam int HalfRing   = NumSensors / 2;
   localparam int CntW       = $clog2(NumSensors + 2 * WINDOW_HALF + CORDIC_STEPS + 2);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SMOOTH = 7'b0000010,
      ST_FILL   = 7'b0000100,
      ST_SUM    = 7'b0001000,
      ST_CORDIC = 7'b0010000,
      ST_FIN    = 7'b0100000,
      ST_OUT    = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              accept;
   logic              closes;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign accept     = req_tvalid && req_tready;
   assign closes     = (32'(req_pos) == HalfRing - 1);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && 32'(req_pos) < HalfRing) begin
               cmd.load_raw = 1'b1;
               if (closes) begin
                  cmd.smooth_start = 1'b1;
                  cnt_in   = '0;
                  state_in = ST_SMOOTH;
               end
            end
         end
         ST_SMOOTH: begin
            cmd.smooth_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == NumSensors - 1) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.ball_seen) begin
               cmd.sum_start = 1'b1;
               cnt_in   = '0;
               state_in = ST_SUM;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == 2 * WINDOW_HALF) begin
               // all ones marks the set-up cycle, above any step count
               state_in = ST_CORDIC;
               cnt_in   = '1;
            end
         end
         ST_CORDIC: begin
            if (cnt_ff == '1) begin
               cmd.cordic_start = 1'b1;
               cnt_in = '0;
            end else begin
               cmd.cordic_step = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               if (status.cordic_done || 32'(cnt_ff) == CORDIC_STEPS - 1) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/irbde_dpath.sv =====
// ----------------------------------------------------------------------------
// irbde_dpath
// level stores, smoothing, peak search, window sum and cordic vectoring
// ----------------------------------------------------------------------------
`default_nettype none

module irbde_dpath #(
   parameter int WINDOW_HALF  = irbde_pkg::WindowHalfDefault,
   parameter int CORDIC_STEPS = irbde_pkg::CordicStepsDefault
) (
   input  wire                     clock,
   input  wire                     reset,
   input  irbde_pkg::cmd_type      cmd,
   output irbde_pkg::status_type   status,
   input  wire  [2:0]              req_pos,
   input  wire  [15:0]             req_x,
   input  wire  [15:0]             req_y,
   output logic [8:0]              dir_out,
   output logic                    seen_out,
   output logic [3:0]              peak_id_out,
   output logic [5:0]              peak_lvl_out
);

   localparam int NumSensors = irbde_pkg::NumSensors;
   localparam int HalfRing   = NumSensors / 2;
   localparam int IdW        = $clog2(NumSensors);
   localparam int LW         = irbde_pkg::LevelWidth;
   localparam int AW         = irbde_pkg::AccWidth;
   localparam int CW         = irbde_pkg::CordWidth;
   localparam int GW         = irbde_pkg::AngWidth;
   localparam int SW         = $clog2(CORDIC_STEPS + 1);

   // level stores
   logic signed [LW-1:0] raw_ff    [NumSensors];
   logic signed [LW-1:0] smooth_ff [NumSensors];
   logic                 smooth_vld_ff [NumSensors];
   logic signed [LW-1:0] lv_ff     [NumSensors];

   logic [IdW-1:0]       idx_ff;
   logic signed [LW-1:0] best_ff;
   logic [IdW-1:0]       best_id_ff;
   logic [IdW-1:0]       win_id_ff;
   logic signed [AW-1:0] xa_ff, ya_ff;
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic signed [GW-1:0] ang_ff;
   logic [SW-1:0]        step_ff;
   logic [8:0]           dir_ff;

   logic signed [LW-1:0] old_lv;
   logic signed [10:0]   smix;
   logic [9:0]           smag;
   logic [17:0]          sq;
   logic [6:0]           sdiv;
   logic signed [LW-1:0] snew;
   logic signed [LW-1:0] lid;
   logic signed [AW+17:0] px, py;
   logic signed [AW-1:0]  xa_in, ya_in;
   logic [3:0]           tix;
   logic signed [CW-1:0] shx, shy;
   logic signed [GW+17:0] deg_prod;
   logic signed [GW-1:0]  deg_q;
   logic signed [LW:0]   avg_a, avg_b;

   assign old_lv = smooth_vld_ff[idx_ff] ? smooth_ff[idx_ff] : '0;
   assign smix   = 11'(6) * 11'(raw_ff[idx_ff]) + 11'(4) * 11'(old_lv);

   // divide by ten toward zero: magnitude times 205/2048, exact for |smix| <= 600
   assign smag = smix[10] ? 10'(-smix) : 10'(smix);
   assign sq   = 18'(smag) * 18'd205;
   assign sdiv = sq[17:11];
   assign snew = smix[10] ? LW'(-$signed(sdiv)) : LW'($signed(sdiv));

   // window table index and products
   assign lid = lv_ff[win_id_ff];
   assign tix = 4'((32'(win_id_ff) * 16) / NumSensors);
   assign px  = (AW+18)'(xa_ff) * 34'sd32768 + (AW+18)'(lid) * (AW+18)'(irbde_pkg::cos_q15(tix));
   assign py  = (AW+18)'(ya_ff) * 34'sd32768 + (AW+18)'(lid) * (AW+18)'(irbde_pkg::sin_q15(tix));
   assign xa_in = AW'(px / 34'sd32768);
   assign ya_in = AW'(py / 34'sd32768);

   // floor shifts for cordic
   assign shx = cx_ff >>> step_ff;
   assign shy = cy_ff >>> step_ff;

   assign avg_a = (LW+1)'(lv_ff[HalfRing-2]) + (LW+1)'(lv_ff[HalfRing]);
   assign avg_b = (LW+1)'(lv_ff[0]) + (LW+1)'(lv_ff[NumSensors-2]);

   assign deg_prod = (GW+18)'(ang_ff) * (GW+18)'(65538);
   assign deg_q    = GW'(deg_prod / (GW+18)'(64'sd1 <<< 32));

   assign status.ball_seen   = (best_ff > 0);
   assign status.cordic_done = (cy_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumSensors; i++) smooth_vld_ff[i] <= 1'b0;
      end else if (cmd.smooth_step) begin
         smooth_vld_ff[idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      // capture the two levels of one position
      if (cmd.load_raw) begin
         raw_ff[IdW'(req_pos)] <= LW'(7'sd60 - $signed(irbde_pkg::div1000(req_x)));
         raw_ff[IdW'(req_pos) + IdW'(HalfRing)] <=
            LW'(7'sd60 - $signed(irbde_pkg::div1000(req_y)));
      end
      if (cmd.smooth_start) begin
         idx_ff     <= '0;
         best_ff    <= '0;
         best_id_ff <= '0;
      end
      // one sensor per cycle: smooth, store, track last peak
      if (cmd.smooth_step) begin
         smooth_ff[idx_ff] <= snew;
         lv_ff[idx_ff]     <= snew;
         idx_ff            <= idx_ff + 1'b1;
         if (snew >= best_ff) begin
            if (snew > best_ff) best_ff <= snew;
            best_id_ff <= idx_ff;
         end
      end
      // neighbour averages for the two gap sensors
      if (cmd.fill_step) begin
         lv_ff[HalfRing-1]   <= LW'(avg_a / 8'sd2);
         lv_ff[NumSensors-1] <= LW'(avg_b / 8'sd2);
      end
      if (cmd.sum_start) begin
         xa_ff     <= '0;
         ya_ff     <= '0;
         win_id_ff <= IdW'(32'(best_id_ff) + NumSensors - WINDOW_HALF);
      end
      if (cmd.sum_step) begin
         xa_ff     <= xa_in;
         ya_ff     <= ya_in;
         win_id_ff <= win_id_ff + 1'b1;
      end
      // cordic preparation: half turn when x is negative
      if (cmd.cordic_start) begin
         step_ff <= '0;
         if (xa_ff < 0) begin
            cx_ff  <= -(CW'(xa_ff) <<< 16);
            cy_ff  <= -(CW'(ya_ff) <<< 16);
            ang_ff <= (ya_ff >= 0) ? GW'(180 * 65536) : -GW'(180 * 65536);
         end else begin
            cx_ff  <= CW'(xa_ff) <<< 16;
            cy_ff  <= CW'(ya_ff) <<< 16;
            ang_ff <= '0;
         end
      end
      if (cmd.cordic_step && cy_ff != '0) begin
         step_ff <= step_ff + 1'b1;
         if (cy_ff > 0) begin
            cx_ff  <= cx_ff + shy;
            cy_ff  <= cy_ff - shx;
            ang_ff <= ang_ff + GW'(irbde_pkg::atan_q16(5'(step_ff)));
         end else begin
            cx_ff  <= cx_ff - shy;
            cy_ff  <= cy_ff + shx;
            ang_ff <= ang_ff - GW'(irbde_pkg::atan_q16(5'(step_ff)));
         end
      end
      // whole degrees and wrap
      if (cmd.finish) begin
         if (!status.ball_seen) dir_ff <= '0;
         else if (deg_q > 360) dir_ff <= 9'(deg_q - 360);
         else if (deg_q < 1)   dir_ff <= 9'(deg_q + 360);
         else                  dir_ff <= 9'(deg_q);
      end
   end

   assign dir_out      = dir_ff;
   assign seen_out     = status.ball_seen;
   assign peak_id_out  = 4'(best_id_ff);
   assign peak_lvl_out = status.ball_seen ? 6'(best_ff) : 6'd0;

endmodule

`default_nettype wire

// ===== rtl/ir_ball_direction_estimator_core.sv =====
// ----------------------------------------------------------------------------
// ir_ball_direction_estimator_core
// bearing of an ir ball from a multiplexed ring of sensors
// ----------------------------------------------------------------------------
// Each request carries one multiplexer position and two conversions. Requests
// below the last position give no response. The request at the last position
// starts the frame walk: smoothing and peak search at one sensor per cycle, a
// fill step, the window sum over 2*WINDOW_HALF+1 sensors, a set-up step, up to
// CORDIC_STEPS vectoring steps and a scaling step; with no ball seen, the walk
// goes from fill straight to scaling. No request is taken during the walk,
// then one response is held until taken.
`default_nettype none

module ir_ball_direction_estimator_core #(
   parameter int WINDOW_HALF  = irbde_pkg::WindowHalfDefault,
   parameter int CORDIC_STEPS = irbde_pkg::CordicStepsDefault
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,  // mux_position[2:0], x_sample[18:3], y_sample[34:19]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata   // direction_degrees[8:0], ball_seen[9],
                                   // peak_sensor[13:10], peak_level[19:14]
);

   irbde_pkg::cmd_type    cmd;
   irbde_pkg::status_type status;
   logic [8:0] dir;
   logic       seen;
   logic [3:0] pid;
   logic [5:0] plv;

   irbde_ctrl #(.WINDOW_HALF(WINDOW_HALF), .CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_pos(req_tdata[2:0]), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .cmd(cmd), .status(status)
   );

   irbde_dpath #(.WINDOW_HALF(WINDOW_HALF), .CORDIC_STEPS(CORDIC_STEPS)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_pos(req_tdata[2:0]), .req_x(req_tdata[18:3]), .req_y(req_tdata[34:19]),
      .dir_out(dir), .seen_out(seen), .peak_id_out(pid), .peak_lvl_out(plv)
   );

   assign rsp_tdata = {4'd0, plv, pid, seen, dir};

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives frames of multiplexed sensor conversions into the direction
// estimator and checks every bearing response against an internal predictor
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   localparam int HalfRing     = 8;
   localparam int LastPosition = HalfRing - 1;
   localparam int WatchLimit   = 20000;
   localparam int TailCycles   = 100;

   typedef struct packed {
      logic [2:0]  mux_position;
      logic [15:0] x_sample;
      logic [15:0] y_sample;
   } sample_request_t;

   // lowest field last, matching the response packing
   typedef struct packed {
      logic [5:0] peak_level;
      logic [3:0] peak_sensor;
      logic       ball_seen;
      logic [8:0] direction_degrees;
   } bearing_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   sample_request_t pending_requests[$];
   bearing_t        expected_bearings[$];
   int              raw_level[16];
   int              smooth_level[16];
   int              mismatch_count = 0;
   int              quiet_cycles = 0;
   bit              stimulus_done = 1'b0;
   bit              hold_sender = 1'b0;
   bit              hold_done = 1'b0;
   int              send_gap = 0;
   int              take_gap = 0;

   ir_ball_direction_estimator_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // gap length: mostly short, occasionally long, often none
   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // floor shift of a signed value
   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   // q15 sine table entry
   function automatic int sine_entry(int t);
      int tab[16];
      tab = '{0, 12540, 23171, 30274, 32768, 30274, 23171, 12540,
              0, -12540, -23171, -30274, -32768, -30274, -23171, -12540};
      return tab[t & 15];
   endfunction

   // whole-degree bearing by cordic vectoring
   function automatic int vector_bearing(int xs, int ys);
      longint atan_q16[16];
      longint x, y, ang, nx, ny, deg;
      atan_q16 = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115};
      x = longint'(xs) * 65536;
      y = longint'(ys) * 65536;
      ang = 0;
      if (x < 0) begin
         ang = (y >= 0) ? 180 * 65536 : -180 * 65536;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         if (y == 0) break;
         if (y > 0) begin
            nx = x + floor_shr(y, i);
            ny = y - floor_shr(x, i);
            ang += atan_q16[i];
         end else begin
            nx = x - floor_shr(y, i);
            ny = y + floor_shr(x, i);
            ang -= atan_q16[i];
         end
         x = nx;
         y = ny;
      end
      deg = (ang * 65538) / (longint'(1) << 32);
      if (deg > 360) deg -= 360;
      else if (deg < 1) deg += 360;
      return int'(deg);
   endfunction

   // update the sensor model for one request, queue a bearing at frame close
   task automatic predict_bearing(sample_request_t r);
      int lv[16];
      int best, best_id, xa, ya, id;
      bearing_t b;
      if (r.mux_position > LastPosition) return;
      raw_level[r.mux_position]            = 60 - int'(r.x_sample) / 1000;
      raw_level[r.mux_position + HalfRing] = 60 - int'(r.y_sample) / 1000;
      if (r.mux_position != LastPosition) return;
      best = 0;
      best_id = 0;
      for (int i = 0; i < 16; i++) begin
         lv[i] = (6 * raw_level[i] + 4 * smooth_level[i]) / 10;
         smooth_level[i] = lv[i];
         if (lv[i] > best) best = lv[i];
         if (lv[i] == best) best_id = i;
      end
      lv[HalfRing - 1] = (lv[HalfRing - 2] + lv[HalfRing]) / 2;
      lv[15] = (lv[0] + lv[14]) / 2;
      b = '0;
      if (best > 0) begin
         xa = 0;
         ya = 0;
         for (int k = -2; k <= 2; k++) begin
            id = (best_id + 16 + k) % 16;
            xa = (longint'(xa) * 32768 + longint'(lv[id]) * sine_entry(id + 4)) / 32768;
            ya = (longint'(ya) * 32768 + longint'(lv[id]) * sine_entry(id)) / 32768;
         end
         b.direction_degrees = 9'(vector_bearing(xa, ya));
         b.ball_seen = 1'b1;
         b.peak_level = 6'(best);
      end
      b.peak_sensor = 4'(best_id);
      expected_bearings.push_back(b);
   endtask

   // one full frame, positions in order, each level chosen by the caller's mode
   task automatic queue_frame(int mode);
      sample_request_t r;
      for (int p = 0; p < HalfRing; p++) begin
         r.mux_position = 3'(p);
         case (mode)
            0: begin r.x_sample = 16'hFFFF; r.y_sample = 16'hFFFF; end
            1: begin r.x_sample = 16'h0000; r.y_sample = 16'h0000; end
            default: begin
               r.x_sample = 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 60999));
               r.y_sample = 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 60999));
            end
         endcase
         pending_requests.push_back(r);
         // occasional noise: repeated writes of positions below the last
         if (mode > 1 && $urandom_range(0, 9) == 0) begin
            r.mux_position = 3'(p == LastPosition ? 0 : $urandom_range(0, LastPosition - 1));
            r.x_sample = 16'($urandom);
            r.y_sample = 16'($urandom);
            pending_requests.push_back(r);
         end
      end
   endtask

   // stimulus
   initial begin
      sample_request_t r;
      queue_frame(0);               // all levels negative: no ball
      queue_frame(1);               // every level at its top
      queue_frame(1);
      // two bright sensors at equal level, for the last-peak rule
      for (int p = 0; p < HalfRing; p++) begin
         r.mux_position = 3'(p);
         r.x_sample = (p == 3) ? 16'd0 : 16'd59999;
         r.y_sample = (p == 3) ? 16'd0 : 16'd65535;
         pending_requests.push_back(r);
      end
      for (int n = 0; n < 110; n++) queue_frame(2);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (pending_requests.size() > 0) @(posedge clock);
      stimulus_done = 1'b1;
   end

   // sender: holds back once mid-run until all bearings have come
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            predict_bearing(sample_request_t'{req_tdata[2:0], req_tdata[18:3],
                                              req_tdata[34:19]});
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() <= 500 && !hold_done) begin
               hold_sender <= 1'b1;
               hold_done   <= 1'b1;
            end
            if (hold_sender && expected_bearings.size() == 0) hold_sender <= 1'b0;
            if (send_gap > 0 || hold_sender || pending_requests.size() == 0) begin
               req_tvalid <= 1'b0;
               if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
               r_send: begin
                  sample_request_t nr;
                  nr = pending_requests.pop_front();
                  req_tdata <= {5'd0, nr.y_sample, nr.x_sample, nr.mux_position};
                  req_tvalid <= 1'b1;
                  send_gap <= random_gap();
               end
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      bearing_t got, want;
      if (!reset) begin
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got = bearing_t'(rsp_tdata[19:0]);
            if (expected_bearings.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected response %h", rsp_tdata);
            end else begin
               want = expected_bearings.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("bearing (deg seen sensor level): expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                              want.direction_degrees, want.ball_seen, want.peak_sensor,
                              want.peak_level, got.direction_degrees, got.ball_seen,
                              got.peak_sensor, got.peak_level);
               end
            end
         end
         if (take_gap > 0) begin
            rsp_tready <= 1'b0;
            take_gap <= take_gap - 1;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_tvalid) take_gap <= random_gap();
         end
      end
   end

   // end of run and watchdog
   initial begin
      bit timed_out;
      timed_out = 1'b0;
      fork
         begin
            wait (stimulus_done && !req_tvalid && expected_bearings.size() == 0);
            repeat (TailCycles) @(posedge clock);
         end
         begin
            wait (quiet_cycles >= WatchLimit);
            timed_out = 1'b1;
         end
      join_any
      if (timed_out || mismatch_count != 0 || expected_bearings.size() != 0)
         $display("ir_ball_direction_estimator_core: mismatch");
      else
         $display("ir_ball_direction_estimator_core: match");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/irbde_pkg.sv
rtl/irbde_ctrl.sv
rtl/irbde_dpath.sv
rtl/ir_ball_direction_estimator_core.sv
sim/testbench.sv
